// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that stays active through reset.
`define ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: label");

// Concurrent assertion that is disabled while reset is high.
`define ASSERT_ACTIVE(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: label");

`endif

// ===== hw/rtl/fsjis_pkg.sv =====
// Types, constants and the punctuation lookup of the full-width Shift-JIS encoder.
package fsjis_pkg;

  localparam logic [1:0] REG_LEAD_BYTE    = 2'd0;
  localparam logic [1:0] REG_UPPER_OFFSET = 2'd1;
  localparam logic [1:0] REG_LOWER_OFFSET = 2'd2;

  localparam logic [7:0] RESET_LEAD_BYTE    = 8'h82;
  localparam logic [7:0] RESET_UPPER_OFFSET = 8'h1F;
  localparam logic [7:0] RESET_LOWER_OFFSET = 8'h20;

  localparam logic [7:0] SYMBOL_PAGE   = 8'h81;
  localparam logic [7:0] SPACE_LOW     = 8'h40;
  localparam logic [7:0] QUOTE_OPEN_LO = 8'h67;
  localparam logic [7:0] QUOTE_CLOSE_LO = 8'h68;
  localparam logic [7:0] UNKNOWN_CHAR  = 8'h3F;

  localparam logic [15:0] CU_ELLIPSIS   = 16'd8230;
  localparam logic [15:0] CU_MIDDLE_DOT = 16'd12539;
  localparam logic [15:0] CU_LSQUO      = 16'd8216;
  localparam logic [15:0] CU_RSQUO      = 16'd8217;
  localparam logic [15:0] CU_LDQUO      = 16'd8220;
  localparam logic [15:0] CU_RDQUO      = 16'd8221;
  localparam logic [15:0] CU_DQUOTE     = 16'h0022;
  localparam logic [15:0] CU_BACKSLASH  = 16'h005C;

  // Mapping of one code unit: no bytes, one byte or a pair.
  typedef struct packed {
    logic       none;
    logic       two;
    logic       unsup;
    logic [7:0] byte0;
    logic [7:0] byte1;
  } map_res_t;

  // Low byte on the 0x81 page for ASCII punctuation; zero where none exists.
  function automatic logic [7:0] punct_low(input logic [6:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (c)
      7'h26: r = 8'h95;
      7'h3E: r = 8'h84;
      7'h5B: r = 8'h6D;
      7'h5D: r = 8'h6E;
      7'h3C: r = 8'h83;
      7'h7E: r = 8'h60;
      7'h21: r = 8'h49;
      7'h2E: r = 8'h44;
      7'h3A: r = 8'h46;
      7'h3B: r = 8'h47;
      7'h3F: r = 8'h48;
      7'h2C: r = 8'h43;
      7'h2D: r = 8'h5D;
      7'h2A: r = 8'h96;
      7'h28: r = 8'h69;
      7'h29: r = 8'h6A;
      7'h2B: r = 8'h7B;
      7'h27: r = 8'h66;
      7'h2F: r = 8'h5E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/fsjis_map.sv =====
// Combinational mapping of one UTF-16 code unit to its Shift-JIS bytes and mode updates.
module fsjis_map (
  input  logic [15:0]         code_unit,
  input  logic                text_start,
  input  logic                passthrough,
  input  logic                quote_open,
  input  logic [7:0]          lead_byte,
  input  logic [7:0]          upper_offset,
  input  logic [7:0]          lower_offset,
  output fsjis_pkg::map_res_t res,
  output logic                passthrough_next,
  output logic                quote_open_next
);
  import fsjis_pkg::*;

  logic       pt_eff;
  logic       is_upper;
  logic       is_lower;
  logic       is_digit;
  logic       is_space;
  logic       is_ascii;
  logic [7:0] plow;
  logic [7:0] offset;

  assign pt_eff   = passthrough & ~text_start;
  assign is_ascii = (code_unit < 16'h0080);
  assign is_upper = (code_unit >= 16'h0041 && code_unit <= 16'h005A) ||
                    (code_unit >= 16'h0400 && code_unit <= 16'h042F);
  assign is_lower = (code_unit >= 16'h0061 && code_unit <= 16'h007A) ||
                    (code_unit >= 16'h0430 && code_unit <= 16'h045F);
  assign is_digit = (code_unit >= 16'h0030 && code_unit <= 16'h0039);
  assign is_space = (code_unit >= 16'h0009 && code_unit <= 16'h000D) ||
                    (code_unit == 16'h0020);
  assign plow     = punct_low(code_unit[6:0]);
  assign offset   = is_lower ? lower_offset : upper_offset;

  always_comb begin
    res              = '0;
    passthrough_next = pt_eff;
    quote_open_next  = quote_open;
    if (code_unit == CU_ELLIPSIS || code_unit == CU_MIDDLE_DOT ||
        code_unit == CU_LSQUO || code_unit == CU_RSQUO ||
        code_unit == CU_LDQUO || code_unit == CU_RDQUO) begin
      res.two   = 1'b1;
      res.byte0 = SYMBOL_PAGE;
      case (code_unit)
        CU_ELLIPSIS:   res.byte1 = 8'h63;
        CU_MIDDLE_DOT: res.byte1 = 8'h45;
        CU_LSQUO:      res.byte1 = 8'h65;
        CU_RSQUO:      res.byte1 = 8'h66;
        CU_LDQUO:      res.byte1 = 8'h67;
        default:       res.byte1 = 8'h68;
      endcase
    end else if (is_upper || is_lower || is_digit) begin
      if (pt_eff) begin
        res.byte0 = is_ascii ? code_unit[7:0] : UNKNOWN_CHAR;
      end else begin
        res.two   = 1'b1;
        res.byte0 = lead_byte;
        res.byte1 = code_unit[7:0] + offset;
      end
    end else if (is_space) begin
      res.two   = 1'b1;
      res.byte0 = SYMBOL_PAGE;
      res.byte1 = SPACE_LOW;
    end else if (code_unit == CU_DQUOTE) begin
      res.two         = 1'b1;
      res.byte0       = SYMBOL_PAGE;
      res.byte1       = quote_open ? QUOTE_CLOSE_LO : QUOTE_OPEN_LO;
      quote_open_next = ~quote_open;
    end else if (code_unit == CU_BACKSLASH) begin
      res.none         = 1'b1;
      passthrough_next = ~pt_eff;
    end else if (is_ascii && plow != 8'h00) begin
      res.two   = 1'b1;
      res.byte0 = SYMBOL_PAGE;
      res.byte1 = plow;
    end else begin
      res.unsup = 1'b1;
    end
  end

endmodule

// ===== hw/rtl/fullwidth_sjis_text_encoder.sv =====
// Top level of the full-width Shift-JIS text encoder with its register port.
//
// Input channel (in_valid/in_ready) carries one UTF-16 code_unit per request,
// with text_start set on the first character of a text. The output channel
// (out_valid/out_ready) carries one Shift-JIS byte per request, with
// last_byte set on the final byte of a character and unsupported set on the
// single zero byte given for a character that has no mapping here. A
// backslash produces no output and toggles the ASCII pass-through mode.
// A request is held in an input register and, once the output register is
// free or sending its last byte, mapped into the output register, from which
// its first byte is offered. The output register sends one byte per cycle
// while the receiver is ready, so a two-byte character goes out as two bytes
// in turn, a one-byte character as one and an empty character as none; the
// byte-wide output port sets this rate. A new request is taken whenever the
// input register is empty or moves on in the same cycle.
// When the receiver stalls, the output register holds its byte and the
// input register fills, after which in_ready falls. Synchronous reset empties
// both registers, clears the pass-through and quote flags and restores the
// configuration registers to their reset values.
module fullwidth_sjis_text_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] code_unit,
  input  logic        text_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic        unsupported
);
  import fsjis_pkg::*;

  logic [7:0] lead_reg;
  logic [7:0] upper_offset;
  logic [7:0] lower_offset;
  logic       passthrough;
  logic       quote_open;

  logic        held;
  logic [15:0] held_cu;
  logic        held_start;

  logic       pair_valid;
  logic       pair_second;
  map_res_t   pair;

  map_res_t   res;
  logic       passthrough_next;
  logic       quote_open_next;
  logic       advance;
  logic       out_fire;
  logic       wr_en;

  assign pready    = 1'b1;
  assign wr_en     = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_reg     <= RESET_LEAD_BYTE;
      upper_offset <= RESET_UPPER_OFFSET;
      lower_offset <= RESET_LOWER_OFFSET;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_LEAD_BYTE:    lead_reg     <= pwdata[7:0];
        REG_UPPER_OFFSET: upper_offset <= pwdata[7:0];
        REG_LOWER_OFFSET: lower_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_LEAD_BYTE:    prdata = {24'd0, lead_reg};
      REG_UPPER_OFFSET: prdata = {24'd0, upper_offset};
      REG_LOWER_OFFSET: prdata = {24'd0, lower_offset};
      default:          prdata = 32'd0;
    endcase
  end

  fsjis_map u_map (
    .code_unit        (held_cu),
    .text_start       (held_start),
    .passthrough      (passthrough),
    .quote_open       (quote_open),
    .lead_byte        (lead_reg),
    .upper_offset     (upper_offset),
    .lower_offset     (lower_offset),
    .res              (res),
    .passthrough_next (passthrough_next),
    .quote_open_next  (quote_open_next)
  );

  assign out_valid   = pair_valid;
  assign out_byte    = pair_second ? pair.byte1 : pair.byte0;
  assign last_byte   = ~pair.two | pair_second;
  assign unsupported = pair.unsup;
  assign out_fire    = out_valid & out_ready;
  assign advance     = held & (~pair_valid | (out_fire & last_byte));
  assign in_ready    = ~held | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_cu    <= code_unit;
      held_start <= text_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid  <= 1'b0;
      pair_second <= 1'b0;
      passthrough <= 1'b0;
      quote_open  <= 1'b0;
    end else if (advance) begin
      pair_valid  <= ~res.none;
      pair_second <= 1'b0;
      passthrough <= passthrough_next;
      quote_open  <= quote_open_next;
    end else if (out_fire) begin
      if (last_byte) begin
        pair_valid <= 1'b0;
      end else begin
        pair_second <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pair <= res;
    end
  end

endmodule

// ===== hw/rtl/fsjis_checker.sv =====
// Port-level checker for the full-width Shift-JIS encoder, bound to its top level.
`include "assert_macros.svh"

module fsjis_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       last_byte,
  input logic       unsupported
);

  `ASSERT_ALWAYS(a_reset_empties_output, rst |=> !out_valid)
  `ASSERT_ACTIVE(a_unsup_is_single_zero, out_valid && unsupported |-> last_byte && out_byte == 8'h00)
  `ASSERT_ACTIVE(a_second_byte_follows, out_valid && out_ready && !last_byte |=> out_valid && last_byte)
  `ASSERT_ACTIVE(a_stalled_byte_holds, out_valid && !out_ready |=> out_valid && $stable(out_byte))

endmodule

bind fullwidth_sjis_text_encoder fsjis_checker u_fsjis_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_byte    (out_byte),
  .last_byte   (last_byte),
  .unsupported (unsupported)
);

// ===== tb/tb_fullwidth_sjis_text_encoder.sv =====
// Self-checking testbench of the full-width Shift-JIS text encoder.
module tb_fullwidth_sjis_text_encoder;
  import fsjis_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       last_flag;
    logic       unsup;
  } sjis_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] code_unit = '0;
  logic        text_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic        unsupported;

  sjis_byte_t sjis_bytes_due[$];
  logic [7:0] lead_reg = RESET_LEAD_BYTE;
  logic [7:0] upper_off_reg = RESET_UPPER_OFFSET;
  logic [7:0] lower_off_reg = RESET_LOWER_OFFSET;
  logic       pass_mode = 1'b0;
  logic       quote_flag = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int mismatches = 0;

  logic [15:0] punct_set [21] = '{16'h26, 16'h3E, 16'h5B, 16'h5D, 16'h3C, 16'h7E, 16'h21,
                                  16'h2E, 16'h3A, 16'h3B, 16'h3F, 16'h2C, 16'h2D, 16'h2A,
                                  16'h28, 16'h29, 16'h2B, 16'h27, 16'h2F, CU_DQUOTE,
                                  16'h24};
  logic [15:0] typo_set [6] = '{CU_ELLIPSIS, CU_MIDDLE_DOT, CU_LSQUO, CU_RSQUO, CU_LDQUO,
                                CU_RDQUO};
  logic [15:0] edge_set [14] = '{16'h40, 16'h5B, 16'h60, 16'h7B, 16'h2F, 16'h3A, 16'h3FF,
                                 16'h460, 16'h08, 16'h0E, 16'h1F, 16'h21, 16'h7F, 16'h80};

  fullwidth_sjis_text_encoder dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready), .in_valid(in_valid),
    .in_ready(in_ready), .code_unit(code_unit), .text_start(text_start),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .last_byte(last_byte), .unsupported(unsupported)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic logic [7:0] punct_low_byte(input logic [15:0] cu);
    logic [7:0] low;
    low = 8'h00;
    if (cu < 16'h80) begin
      case (cu[6:0])
        7'h26: low = 8'h95;
        7'h3E: low = 8'h84;
        7'h5B: low = 8'h6D;
        7'h5D: low = 8'h6E;
        7'h3C: low = 8'h83;
        7'h7E: low = 8'h60;
        7'h21: low = 8'h49;
        7'h2E: low = 8'h44;
        7'h3A: low = 8'h46;
        7'h3B: low = 8'h47;
        7'h3F: low = 8'h48;
        7'h2C: low = 8'h43;
        7'h2D: low = 8'h5D;
        7'h2A: low = 8'h96;
        7'h28: low = 8'h69;
        7'h29: low = 8'h6A;
        7'h2B: low = 8'h7B;
        7'h27: low = 8'h66;
        7'h2F: low = 8'h5E;
        default: low = 8'h00;
      endcase
    end
    return low;
  endfunction

  task automatic push_pair(input logic [7:0] first, input logic [7:0] second);
    sjis_bytes_due.push_back('{data: first, last_flag: 1'b0, unsup: 1'b0});
    sjis_bytes_due.push_back('{data: second, last_flag: 1'b1, unsup: 1'b0});
  endtask

  task automatic push_one(input logic [7:0] value, input logic unsup);
    sjis_bytes_due.push_back('{data: value, last_flag: 1'b1, unsup: unsup});
  endtask

  task automatic encode_letter(input logic [15:0] cu, input logic [7:0] offset);
    if (pass_mode) begin
      push_one((cu < 16'h80) ? cu[7:0] : UNKNOWN_CHAR, 1'b0);
    end else begin
      push_pair(lead_reg, cu[7:0] + offset);
    end
  endtask

  task automatic predict_sjis(input logic [15:0] cu, input logic ts);
    logic [7:0] punct;
    punct = punct_low_byte(cu);
    if (ts) pass_mode = 1'b0;
    if (cu == CU_ELLIPSIS) push_pair(SYMBOL_PAGE, 8'h63);
    else if (cu == CU_MIDDLE_DOT) push_pair(SYMBOL_PAGE, 8'h45);
    else if (cu == CU_LSQUO) push_pair(SYMBOL_PAGE, 8'h65);
    else if (cu == CU_RSQUO) push_pair(SYMBOL_PAGE, 8'h66);
    else if (cu == CU_LDQUO) push_pair(SYMBOL_PAGE, QUOTE_OPEN_LO);
    else if (cu == CU_RDQUO) push_pair(SYMBOL_PAGE, QUOTE_CLOSE_LO);
    else if ((cu >= 16'h41 && cu <= 16'h5A) || (cu >= 16'h400 && cu <= 16'h42F))
      encode_letter(cu, upper_off_reg);
    else if ((cu >= 16'h61 && cu <= 16'h7A) || (cu >= 16'h430 && cu <= 16'h45F))
      encode_letter(cu, lower_off_reg);
    else if (cu >= 16'h30 && cu <= 16'h39) encode_letter(cu, upper_off_reg);
    else if ((cu >= 16'h09 && cu <= 16'h0D) || cu == 16'h20)
      push_pair(SYMBOL_PAGE, SPACE_LOW);
    else if (cu == CU_DQUOTE) begin
      push_pair(SYMBOL_PAGE, quote_flag ? QUOTE_CLOSE_LO : QUOTE_OPEN_LO);
      quote_flag = ~quote_flag;
    end else if (cu == CU_BACKSLASH) pass_mode = ~pass_mode;
    else if (punct != 8'h00) push_pair(SYMBOL_PAGE, punct);
    else push_one(8'h00, 1'b1);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    sjis_byte_t due;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (sjis_bytes_due.size() == 0) begin
        $error("unexpected byte %h", out_byte);
        mismatches++;
      end else begin
        due = sjis_bytes_due.pop_front();
        if (out_byte !== due.data) begin
          $error("out_byte expected %h actual %h", due.data, out_byte);
          mismatches++;
        end
        if (last_byte !== due.last_flag) begin
          $error("last_byte expected %b actual %b", due.last_flag, last_byte);
          mismatches++;
        end
        if (unsupported !== due.unsup) begin
          $error("unsupported expected %b actual %b", due.unsup, unsupported);
          mismatches++;
        end
      end
    end
  end

  task automatic send_char(input logic [15:0] cu, input logic ts);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    code_unit <= cu;
    text_start <= ts;
    do @(posedge clk); while (!in_ready);
    predict_sjis(cu, ts);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sjis_bytes_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEAD_BYTE: lead_reg = value;
      REG_UPPER_OFFSET: upper_off_reg = value;
      REG_LOWER_OFFSET: lower_off_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_encoding(input logic [7:0] lead, input logic [7:0] upper_off,
                              input logic [7:0] lower_off);
    wait_idle();
    write_reg(REG_LEAD_BYTE, lead);
    write_reg(REG_UPPER_OFFSET, upper_off);
    write_reg(REG_LOWER_OFFSET, lower_off);
  endtask

  function automatic logic [15:0] random_code_unit();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) return 16'h41 + 16'($urandom_range(0, 25));
    if (pick < 30) return 16'h61 + 16'($urandom_range(0, 25));
    if (pick < 38) return 16'h30 + 16'($urandom_range(0, 9));
    if (pick < 48) return 16'h400 + 16'($urandom_range(0, 16'h5F));
    if (pick < 55) return ($urandom_range(0, 5) == 0) ? 16'h20 :
                          16'h09 + 16'($urandom_range(0, 4));
    if (pick < 70) return punct_set[$urandom_range(0, 20)];
    if (pick < 74) return CU_BACKSLASH;
    if (pick < 80) return typo_set[$urandom_range(0, 5)];
    if (pick < 86) return edge_set[$urandom_range(0, 13)];
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic test_directed_classes();
    logic [15:0] units [19];
    units = '{16'h41, 16'h7A, 16'h30, 16'h39, 16'h400, 16'h45F, 16'h09, 16'h20,
              CU_ELLIPSIS, CU_MIDDLE_DOT, CU_LSQUO, CU_RSQUO, CU_LDQUO, CU_RDQUO,
              CU_DQUOTE, 16'h26, 16'h2F, 16'h0000, 16'hFFFF};
    foreach (units[i]) send_char(units[i], i == 0);
  endtask

  task automatic test_passthrough();
    send_char(CU_BACKSLASH, 1'b1);
    send_char(16'h51, 1'b0);
    send_char(16'h430, 1'b0);
    send_char(16'h37, 1'b0);
    send_char(16'h20, 1'b0);
    // A new text clears pass-through but the quote keeps closing.
    send_char(CU_DQUOTE, 1'b1);
    send_char(16'h61, 1'b0);
  endtask

  task automatic test_random_texts(input int count);
    int sent;
    int span;
    sent = 0;
    while (sent < count) begin
      span = $urandom_range(1, 24);
      for (int i = 0; i < span; i++) begin
        send_char(random_code_unit(), (i == 0) || ($urandom_range(0, 19) == 0));
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 300;
    test_random_texts(60);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 34;
    recv_idle_pct = 72;
    test_directed_classes();
    test_passthrough();
    test_random_texts(150);
    set_encoding(8'h84, 8'h30, 8'h20);
    test_random_texts(150);
    send_idle_pct = 72;
    recv_idle_pct = 34;
    set_encoding(8'h00, 8'h00, 8'h00);
    test_random_texts(150);
    set_encoding(8'hFF, 8'hFF, 8'hFF);
    test_random_texts(150);
    test_backpressure();
    set_encoding(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    test_random_texts(120);
    set_encoding(RESET_LEAD_BYTE, RESET_UPPER_OFFSET, RESET_LOWER_OFFSET);
    test_random_texts(120);
    wait_idle();
    if (mismatches == 0 && sjis_bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fsjis_pkg.sv
hw/rtl/fsjis_map.sv
hw/rtl/fullwidth_sjis_text_encoder.sv
hw/rtl/fsjis_checker.sv
tb/tb_fullwidth_sjis_text_encoder.sv
